[hdl/ring_extent_release_tail_macros.svh]
`ifndef RING_EXTENT_RELEASE_TAIL_MACROS_SVH
`define RING_EXTENT_RELEASE_TAIL_MACROS_SVH

// same-cycle implication on clk, off during reset
`define RERT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define RERT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rert_pkg.sv]
package rert_pkg;

	localparam int PAGES     = 1024;
	localparam int PAGE_W    = 10;
	localparam int LEN_W     = 11;
	localparam int DIV_W     = 12;
	localparam int DIV_STEPS = 12;
	localparam int DCNT_W    = 4;

	localparam logic [LEN_W-1:0] RING_RESET = LEN_W'(PAGES);
	localparam logic [LEN_W-1:0] RING_MAX   = LEN_W'(PAGES);

	typedef struct packed {
		logic [PAGE_W-1:0] start_page;
		logic [LEN_W-1:0]  length_pages;
	} req_word_t;

	typedef struct packed {
		logic [PAGE_W-1:0] tail_page;
		logic              tail_moved;
	} rsp_word_t;

endpackage

[hdl/ring_extent_release_tail.sv]
// Release tracker for a circular ring of pages. Each request word releases
// an extent (start page, length); the block records the length at the start
// page reduced modulo the ring size, and when the extent begins at the tail
// it walks forward, consuming and clearing released entries and advancing
// the tail modulo the ring size, until it meets a page not yet released.
// One response word per request carries the new tail and whether it moved.
// One request at a time. Each request uses the one shared restoring
// remainder unit, one bit per cycle over a 12-bit dividend, to reduce the
// start page and then the tail; each extent consumed at the tail adds a
// clear of its entry, a further modulo for the advance and one read of the
// length table. After reset the length table is swept to zero, during which
// req_stall is high; ring_pages writes are taken at any time the block is
// idle. A ring_pages value of zero acts as one and values above 1024 act as
// 1024.
module ring_extent_release_tail (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  rert_pkg::req_word_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output rert_pkg::rsp_word_t         rsp,
	input  logic                        cfg_we,
	input  logic [rert_pkg::LEN_W-1:0]  cfg_wdata
);
	import rert_pkg::*;

	typedef enum logic [9:0] {
		ST_CLR      = 10'b0000000001,
		ST_IDLE     = 10'b0000000010,
		ST_MOD_OFF  = 10'b0000000100,
		ST_MOD_TAIL = 10'b0000001000,
		ST_WRITE    = 10'b0000010000,
		ST_CLEAR    = 10'b0000100000,
		ST_MOD_ADV  = 10'b0001000000,
		ST_RD       = 10'b0010000000,
		ST_CHK      = 10'b0100000000,
		ST_DONE     = 10'b1000000000
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    ring_pages_q;
	logic [LEN_W-1:0]    r_q;
	logic [PAGE_W-1:0]   tail_q;
	logic [PAGE_W-1:0]   off_q;
	logic [PAGE_W-1:0]   t_q;
	logic [LEN_W-1:0]    len_q;
	logic                moved_q;
	logic [PAGE_W-1:0]   clr_q;
	logic [LEN_W-1:0]    rd_q;
	logic                rsp_valid_q;
	rsp_word_t           rsp_q;

	logic [DIV_W-1:0]    div_num_q;
	logic [DIV_W-1:0]    div_rem_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic [DIV_W-1:0]    div_trial;
	logic                div_ge;
	logic [DIV_W-1:0]    div_rem_next;
	logic                div_last;
	logic                div_load;
	logic [DIV_W-1:0]    div_load_val;

	logic [LEN_W-1:0]    mem [PAGES];
	logic                mem_we;
	logic [PAGE_W-1:0]   mem_waddr;
	logic [LEN_W-1:0]    mem_wdata;

	logic                accept;
	logic                slot_free;
	logic [LEN_W-1:0]    r_clamp;

	logic                div_busy;
	logic                ptrs_ok;
	logic                done_go;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		priority if (ring_pages_q == '0) begin
			r_clamp = LEN_W'(1);
		end else if (ring_pages_q > RING_MAX) begin
			r_clamp = RING_MAX;
		end else begin
			r_clamp = ring_pages_q;
		end
	end

	// shared remainder unit: one dividend bit per cycle
	assign div_trial    = {div_rem_q[DIV_W-2:0], div_num_q[DIV_W-1]};
	assign div_ge       = div_trial >= {1'b0, r_q};
	assign div_rem_next = div_ge ? (div_trial - {1'b0, r_q}) : div_trial;
	assign div_last     = (div_cnt_q == DCNT_W'(DIV_STEPS - 1));

	always_comb begin
		div_load     = 1'b0;
		div_load_val = '0;
		unique case (state_q)
			ST_IDLE: begin
				div_load     = accept;
				div_load_val = {2'b00, req.start_page};
			end
			ST_MOD_OFF: begin
				div_load     = div_last;
				div_load_val = {2'b00, tail_q};
			end
			ST_CLEAR: begin
				div_load     = 1'b1;
				div_load_val = {2'b00, t_q} + {1'b0, len_q};
			end
			default: begin
				div_load     = 1'b0;
				div_load_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			div_num_q <= div_load_val;
			div_rem_q <= '0;
		end else begin
			div_num_q <= {div_num_q[DIV_W-2:0], 1'b0};
			div_rem_q <= div_rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_load || div_last) begin
			div_cnt_q <= '0;
		end else begin
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = t_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = off_q;
				mem_wdata = len_q;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = t_q;
			end
			default: begin
				mem_we    = 1'b0;
				mem_waddr = t_q;
				mem_wdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[t_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pages_q <= RING_RESET;
		end else if (cfg_we) begin
			ring_pages_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			tail_q      <= '0;
			moved_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + PAGE_W'(1);
					if (clr_q == PAGE_W'(PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						len_q   <= req.length_pages;
						r_q     <= r_clamp;
						moved_q <= 1'b0;
						state_q <= ST_MOD_OFF;
					end
				end
				ST_MOD_OFF: begin
					if (div_last) begin
						off_q   <= div_rem_next[PAGE_W-1:0];
						state_q <= ST_MOD_TAIL;
					end
				end
				ST_MOD_TAIL: begin
					if (div_last) begin
						t_q     <= div_rem_next[PAGE_W-1:0];
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= (off_q == t_q) ? ST_CLEAR : ST_DONE;
				end
				ST_CLEAR: begin
					moved_q <= 1'b1;
					state_q <= ST_MOD_ADV;
				end
				ST_MOD_ADV: begin
					if (div_last) begin
						t_q     <= div_rem_next[PAGE_W-1:0];
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					len_q   <= rd_q;
					state_q <= (rd_q == '0) ? ST_DONE : ST_CLEAR;
				end
				ST_DONE: begin
					if (slot_free) begin
						tail_q            <= t_q;
						rsp_q.tail_page   <= t_q;
						rsp_q.tail_moved  <= moved_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign div_busy = (state_q == ST_MOD_OFF) || (state_q == ST_MOD_TAIL) ||
		(state_q == ST_MOD_ADV);
	assign ptrs_ok  = ({1'b0, off_q} < r_q) && ({1'b0, t_q} < r_q);
	assign done_go  = (state_q == ST_DONE) && slot_free;

	`include "ring_extent_release_tail_macros.svh"

	`RERT_ASSERT_NEXT(a_accept_starts_mod, accept, state_q == ST_MOD_OFF, "modulo not started")
	`RERT_ASSERT_NOW(a_rem_in_range, div_busy, div_rem_q < {1'b0, r_q}, "remainder out of range")
	`RERT_ASSERT_NOW(a_ptrs_in_ring, state_q == ST_WRITE, ptrs_ok, "page index beyond ring")
	`RERT_ASSERT_NEXT(a_done_emits, done_go, rsp_valid && (rsp.tail_page == tail_q), "word missing")

endmodule
